### hdl/pcu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcu_pkg
// Shared types, codes and fixed-point helpers for the phase consensus update.
// ----------------------------------------------------------------------------
package pcu_pkg;

   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 64;
   localparam int CSR_IDX_W  = 3;

   localparam logic CMD_UPDATE = 1'b0;
   localparam logic CMD_TICK   = 1'b1;

   localparam logic MODE_FIRST  = 1'b0;
   localparam logic MODE_SECOND = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_MODE     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COUNT    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_COUPLING = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_DELAY    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_CURRENT  = 3'd6;

   // pi scaled by 2^60
   localparam logic [63:0] PI_Q60 = 64'h3243_F6A8_885A_308D;

   localparam logic signed [63:0] SAT_HI = 64'sh0000_0000_7FFF_FFFF;
   localparam logic signed [63:0] SAT_LO = 64'shFFFF_FFFF_8000_0000;

   typedef struct packed {
      logic               mode;
      logic [4:0]         neighbor_count;
      logic signed [31:0] phase_offset;
      logic signed [31:0] step_gain;
      logic signed [31:0] coupling_gain;
      logic signed [31:0] delay_gain;
      logic signed [31:0] current_gain;
   } cfg_type;

   typedef struct packed {
      logic signed [31:0] prev;
      logic signed [31:0] now;
   } nbr_entry_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_UPD_WR,
      ST_WALK_DIFF,
      ST_WALK_ACC,
      ST_WALK_CUR,
      ST_WALK_DEL,
      ST_DRAIN,
      ST_FINAL_MUL,
      ST_FINAL,
      ST_OUT
   } pcu_state_type;

   function automatic logic [63:0] pi_fixed(input int fb);
      return (PI_Q60 + (64'd1 << (59 - fb))) >> (60 - fb);
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
      logic signed [31:0] y;
      if (x > SAT_HI) begin
         y = SAT_HI[31:0];
      end else if (x < SAT_LO) begin
         y = SAT_LO[31:0];
      end else begin
         y = x[31:0];
      end
      return y;
   endfunction

   // single wrap into -pi..pi
   function automatic logic signed [63:0] wrap_once(input logic signed [63:0] x,
                                                    input logic signed [63:0] pi,
                                                    input logic signed [63:0] two_pi);
      logic signed [63:0] y;
      if (x < -pi) begin
         y = x + two_pi;
      end else if (x > pi) begin
         y = x - two_pi;
      end else begin
         y = x;
      end
      return y;
   endfunction

endpackage
`default_nettype wire

### hdl/pcu_csr.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcu_csr
// Configuration register file, one write per handshake.
// ----------------------------------------------------------------------------
module pcu_csr
   import pcu_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [31:0]          csr_data,
   output cfg_type                   cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_MODE:     cfg_in.mode           = csr_data[0];
            CSR_COUNT:    cfg_in.neighbor_count = csr_data[4:0];
            CSR_OFFSET:   cfg_in.phase_offset   = csr_data;
            CSR_STEP:     cfg_in.step_gain      = csr_data;
            CSR_COUPLING: cfg_in.coupling_gain  = csr_data;
            CSR_DELAY:    cfg_in.delay_gain     = csr_data;
            CSR_CURRENT:  cfg_in.current_gain   = csr_data;
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule
`default_nettype wire

### hdl/pcu_nbr_mem.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcu_nbr_mem
// Neighbor phase store: current and previous phase per slot, registered read.
// ----------------------------------------------------------------------------
module pcu_nbr_mem
   import pcu_pkg::*;
#(
   parameter int DEPTH = 16,
   parameter int AW    = 4
)
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          rd_en,
   input  wire logic [AW-1:0] rd_addr,
   output nbr_entry_type      rd_entry,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire nbr_entry_type wr_entry
);

   nbr_entry_type nbr_mem [DEPTH];
   logic [DEPTH-1:0] slot_vld_ff;
   nbr_entry_type    rd_data_ff;
   logic             rd_vld_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         nbr_mem[wr_addr] <= wr_entry;
      end
      if (rd_en) begin
         rd_data_ff <= nbr_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_vld_ff <= '0;
         rd_vld_ff   <= 1'b0;
      end else begin
         if (wr_en) begin
            slot_vld_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_vld_ff <= slot_vld_ff[rd_addr];
         end
      end
   end

   // never-written slot reads as zero
   assign rd_entry = rd_vld_ff ? rd_data_ff : '0;

endmodule
`default_nettype wire

### hdl/pcu_mul.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcu_mul
// Shared fixed-point multiplier: product stage, then round-to-nearest stage.
// ----------------------------------------------------------------------------
module pcu_mul
   import pcu_pkg::*;
#(
   parameter int FRAC_BITS = 16
)
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               go,
   input  wire logic signed [31:0] op_a,
   input  wire logic signed [31:0] op_b,
   output logic signed [63:0]      res,
   output logic                    res_valid,
   output logic                    busy
);

   localparam logic signed [63:0] HALF = 64'sd1 <<< (FRAC_BITS - 1);

   logic signed [63:0] prod_ff;
   logic signed [63:0] res_ff;
   logic               v1_ff;
   logic               v2_ff;

   always_ff @(posedge clock) begin
      prod_ff <= 64'(op_a) * 64'(op_b);
      res_ff  <= (prod_ff + HALF) >>> FRAC_BITS;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= go;
         v2_ff <= v1_ff;
      end
   end

   assign res       = res_ff;
   assign res_valid = v2_ff;
   assign busy      = v1_ff | v2_ff;

endmodule
`default_nettype wire

### hdl/phase_consensus_update.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// phase_consensus_update
// Phase consensus controller: neighbor phase store and per-tick consensus step.
//
//   channel  dir  fields
//   req      in   tuser: command; tdata: neighbor_index[3:0], value[35:4]
//   rsp      out  tdata: phase[31:0], phase_with_offset[63:32]
//   csr      in   csr_index: register, csr_data: value
//
// Neighbor update: read slot, then write back with history shift.
// Tick: a walk over the n neighbors in use through the neighbor memory, then a final
// product on the shared multiplier; second order also multiplies during the walk.
// Result waits in the output register; a new item is taken meanwhile, but the
// next tick holds in its last state until that register is free.
// Reset is synchronous; slot valid bits make unwritten slots read as zero.
// ----------------------------------------------------------------------------
module phase_consensus_update
   import pcu_pkg::*;
#(
   parameter int MAX_NEIGHBORS = 16,
   parameter int FRAC_BITS     = 16
)
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,  // neighbor_index, value, zero pad
   input  wire logic                  req_tuser,  // command
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0]      rsp_tdata,  // phase, phase_with_offset
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [31:0]           csr_data
);

   localparam int AW = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;
   localparam logic signed [63:0] PI_FX     = pi_fixed(FRAC_BITS);
   localparam logic signed [63:0] TWO_PI_FX = PI_FX + PI_FX;

   cfg_type            cfg;
   logic [4:0]         n_act;
   logic               in_cmd;
   logic [3:0]         in_idx;
   logic signed [31:0] in_val;
   logic               req_fire;
   logic               slot_ok;
   logic               out_free;

   pcu_state_type      state_ff, state_in;
   logic [3:0]         idx_ff, idx_in;
   logic signed [31:0] val_ff, val_in;
   logic signed [31:0] own_ff, own_in;
   logic signed [31:0] own_bef_ff, own_bef_in;
   logic signed [63:0] acc_ff, acc_in;
   logic signed [32:0] dn_ff, dn_in;
   logic signed [31:0] db_ff, db_in;
   logic [4:0]         cnt_ff, cnt_in;
   logic signed [63:0] t_ff, t_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [63:0]        rsp_data_ff, rsp_data_in;

   logic [4:0]         cnt_nxt;
   logic               last;
   logic signed [32:0] diff_now;
   logic signed [32:0] diff_bef;

   logic               rd_en;
   logic [AW-1:0]      rd_addr;
   nbr_entry_type      rd_entry;
   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   nbr_entry_type      wr_entry;

   logic               mul_go;
   logic signed [31:0] mul_a;
   logic signed [31:0] mul_b;
   logic signed [63:0] mul_res;
   logic               mul_res_valid;
   logic               mul_busy;

   pcu_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   pcu_nbr_mem #(
      .DEPTH (MAX_NEIGHBORS),
      .AW    (AW)
   ) u_mem (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (rd_en),
      .rd_addr  (rd_addr),
      .rd_entry (rd_entry),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_entry (wr_entry)
   );

   pcu_mul #(
      .FRAC_BITS (FRAC_BITS)
   ) u_mul (
      .clock     (clock),
      .reset     (reset),
      .go        (mul_go),
      .op_a      (mul_a),
      .op_b      (mul_b),
      .res       (mul_res),
      .res_valid (mul_res_valid),
      .busy      (mul_busy)
   );

   assign n_act = (int'(cfg.neighbor_count) > MAX_NEIGHBORS) ? 5'(MAX_NEIGHBORS)
                                                             : cfg.neighbor_count;
   assign in_cmd   = req_tuser;
   assign in_idx   = req_tdata[3:0];
   assign in_val   = req_tdata[35:4];
   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire = req_tvalid & req_tready;
   assign slot_ok  = ({1'b0, in_idx} < n_act);
   assign out_free = ~rsp_valid_ff | rsp_tready;

   assign cnt_nxt  = cnt_ff + 5'd1;
   assign last     = (cnt_nxt == n_act);
   assign diff_now = 33'(rd_entry.now) - 33'(own_ff);
   assign diff_bef = 33'(rd_entry.prev) - 33'(own_bef_ff);

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (in_cmd == CMD_TICK) begin
                  state_in = (n_act == 5'd0) ? ST_DRAIN : ST_WALK_DIFF;
               end else if (slot_ok) begin
                  state_in = ST_UPD_WR;
               end
            end
         end
         ST_UPD_WR:    state_in = ST_IDLE;
         ST_WALK_DIFF: state_in = (cfg.mode == MODE_SECOND) ? ST_WALK_CUR : ST_WALK_ACC;
         ST_WALK_ACC:  state_in = last ? ST_DRAIN : ST_WALK_DIFF;
         ST_WALK_CUR:  state_in = ST_WALK_DEL;
         ST_WALK_DEL:  state_in = last ? ST_DRAIN : ST_WALK_DIFF;
         ST_DRAIN: begin
            if (!mul_busy) begin
               state_in = ST_FINAL_MUL;
            end
         end
         ST_FINAL_MUL: begin
            if (mul_res_valid) begin
               state_in = ST_FINAL;
            end
         end
         ST_FINAL:     state_in = ST_OUT;
         ST_OUT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default:      state_in = ST_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      idx_in       = idx_ff;
      val_in       = val_ff;
      own_in       = own_ff;
      own_bef_in   = own_bef_ff;
      acc_in       = acc_ff;
      dn_in        = dn_ff;
      db_in        = db_ff;
      cnt_in       = cnt_ff;
      t_in         = t_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rd_en        = 1'b0;
      rd_addr      = AW'(cnt_nxt);
      wr_en        = 1'b0;
      wr_addr      = AW'(idx_ff);
      wr_entry.prev = rd_entry.now;
      wr_entry.now  = val_ff;
      mul_go       = 1'b0;
      mul_a        = cfg.current_gain;
      mul_b        = dn_ff[31:0];

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               idx_in = in_idx;
               val_in = in_val;
               acc_in = '0;
               cnt_in = '0;
               rd_en  = 1'b1;
               rd_addr = (in_cmd == CMD_TICK) ? '0 : AW'(in_idx);
            end
         end
         ST_UPD_WR: begin
            wr_en = 1'b1;
         end
         ST_WALK_DIFF: begin
            if (cfg.mode == MODE_SECOND) begin
               dn_in = 33'(sat32(64'(diff_now)));
               db_in = sat32(64'(diff_bef));
            end else begin
               dn_in = diff_now;
            end
         end
         ST_WALK_ACC: begin
            acc_in = acc_ff + wrap_once(64'(dn_ff), PI_FX, TWO_PI_FX);
            cnt_in = cnt_nxt;
            rd_en  = ~last;
         end
         ST_WALK_CUR: begin
            mul_go = 1'b1;
         end
         ST_WALK_DEL: begin
            mul_go = 1'b1;
            mul_a  = cfg.delay_gain;
            mul_b  = db_ff;
            cnt_in = cnt_nxt;
            rd_en  = ~last;
         end
         ST_DRAIN: begin
            mul_go = ~mul_busy;
            mul_a  = (cfg.mode == MODE_SECOND) ? cfg.coupling_gain : cfg.step_gain;
            mul_b  = sat32(acc_ff);
         end
         ST_FINAL_MUL: begin
            if (mul_res_valid) begin
               if (cfg.mode == MODE_SECOND) begin
                  t_in = (64'(own_ff) <<< 1) - 64'(own_bef_ff) + mul_res;
               end else begin
                  t_in = 64'(own_ff) + mul_res;
               end
            end
         end
         ST_FINAL: begin
            if (cfg.mode == MODE_SECOND) begin
               own_bef_in = own_ff;
               own_in     = sat32(t_ff);
            end else begin
               own_in = sat32(wrap_once(t_ff, PI_FX, TWO_PI_FX));
            end
         end
         ST_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {sat32(64'(own_ff) + 64'(cfg.phase_offset)), own_ff};
            end
         end
         default: begin
            rd_en = 1'b0;
         end
      endcase

      // walk products land here; the final product goes to t
      if (mul_res_valid && state_ff != ST_FINAL_MUL) begin
         acc_in = acc_ff + mul_res;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      val_ff      <= val_in;
      acc_ff      <= acc_in;
      dn_ff       <= dn_in;
      db_ff       <= db_in;
      cnt_ff      <= cnt_in;
      t_ff        <= t_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         own_ff       <= '0;
         own_bef_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         own_ff       <= own_in;
         own_bef_ff   <= own_bef_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_walk_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_WALK_DIFF |-> cnt_ff < n_act)
      else $error("walk index beyond neighbors in use");

   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_OUT)
      else $error("result loaded outside output state");

   a_mul_res_state: assert property (@(posedge clock) disable iff (reset)
      mul_res_valid |-> (state_ff == ST_WALK_DIFF || state_ff == ST_WALK_CUR ||
                         state_ff == ST_WALK_DEL || state_ff == ST_DRAIN ||
                         state_ff == ST_FINAL_MUL))
      else $error("product arrived with no consumer");

   a_first_order_history: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINAL && cfg.mode == MODE_FIRST) |=> $stable(own_bef_ff))
      else $error("delayed phase changed on first-order tick");

endmodule
`default_nettype wire
